[src/tgs_pkg.sv]
// Shared types and constants of the trilinear grid sampler.
package tgs_pkg;

   // Grid span per axis of the field store, as index bits
   localparam int SPAN_BITS = 5;
   localparam int SPAN      = 1 << SPAN_BITS;
   localparam int ADDR_BITS = 3 * SPAN_BITS;

   // Configuration register indexes
   localparam logic [2:0] CFG_SIZE_X      = 3'd0;
   localparam logic [2:0] CFG_SIZE_Y      = 3'd1;
   localparam logic [2:0] CFG_SIZE_Z      = 3'd2;
   localparam logic [2:0] CFG_INV_X       = 3'd3;
   localparam logic [2:0] CFG_INV_Y       = 3'd4;
   localparam logic [2:0] CFG_INV_Z       = 3'd5;
   localparam logic [2:0] CFG_HALF_MASK   = 3'd6;

   // Transaction kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Half a cell in Q16.16, and the fraction value 1.0
   localparam logic [21:0] HALF_Q16 = 22'h008000;
   localparam logic [16:0] ONE_FRAC = 17'h10000;

   typedef logic signed [31:0]   value_type;
   typedef logic [31:0]          ufix_type;
   typedef logic [SPAN_BITS-1:0] index_type;
   typedef logic [2:0]           csr_index_type;
   typedef logic [5:0]           size_type;

endpackage

[src/trilinear_grid_sampler.sv]
// Trilinear grid sampler: field store, shared multiplier and step sequencer.
//
// Usage: the req_ channel carries transactions of two kinds. A write
// (req_kind 0) stores req_entry_value at (req_entry_x, req_entry_y,
// req_entry_z), gives no response and leaves req_ready high.
// A sample (req_kind 1) gives a position; the block answers on the rsp_
// channel with the interpolated value and a saturation flag.
// A sample runs on one shared 33x33 signed multiplier and one field memory
// read port: three axis scalings, eight corner reads and seven linear
// blends, stepped by a counter. req_ready is low from the acceptance of a
// sample until rsp_valid rises, so no new sample is taken before the last
// one is through; writes go at one per cycle while no sample is at work.
// A response waits in an output register; the next transaction is taken
// meanwhile. If the receiver still stalls when a new result is ready, the
// sequencer holds on its last step until the output register frees.
// Configuration goes through csr_we/csr_index/csr_wdata; the user is to write
// it only while idle, which the block itself does not enforce. Reset
// (synchronous, active high) restores the register defaults and drops any
// pending response; the field store keeps no reset and must be written before it is read.
module trilinear_grid_sampler #(
   parameter int MAX_DIM    = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  tgs_pkg::csr_index_type csr_index,
   input  tgs_pkg::ufix_type      csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  tgs_pkg::index_type     req_entry_x,
   input  tgs_pkg::index_type     req_entry_y,
   input  tgs_pkg::index_type     req_entry_z,
   input  tgs_pkg::value_type     req_entry_value,
   input  tgs_pkg::value_type     req_pos_x,
   input  tgs_pkg::value_type     req_pos_y,
   input  tgs_pkg::value_type     req_pos_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tgs_pkg::value_type     rsp_sample_value,
   output logic                   rsp_saturated
);
   import tgs_pkg::*;

   // Sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Sequencer steps
   localparam logic [4:0] SQ_MUL_X   = 5'd0;
   localparam logic [4:0] SQ_CONV_X  = 5'd1;
   localparam logic [4:0] SQ_CONV_Y  = 5'd2;
   localparam logic [4:0] SQ_CONV_Z  = 5'd3;
   localparam logic [4:0] SQ_RD_000  = 5'd4;
   localparam logic [4:0] SQ_RD_100  = 5'd5;
   localparam logic [4:0] SQ_RD_010  = 5'd6;
   localparam logic [4:0] SQ_RD_110  = 5'd7;
   localparam logic [4:0] SQ_MUL_C01 = 5'd8;
   localparam logic [4:0] SQ_FIN_C01 = 5'd9;
   localparam logic [4:0] SQ_RD_001  = 5'd10;
   localparam logic [4:0] SQ_RD_101  = 5'd11;
   localparam logic [4:0] SQ_RD_011  = 5'd12;
   localparam logic [4:0] SQ_RD_111  = 5'd13;
   localparam logic [4:0] SQ_MUL_C11 = 5'd14;
   localparam logic [4:0] SQ_FIN_C11 = 5'd15;
   localparam logic [4:0] SQ_MUL_D1  = 5'd16;
   localparam logic [4:0] SQ_FIN_D1  = 5'd17;
   localparam logic [4:0] SQ_MUL_R   = 5'd18;
   localparam logic [4:0] SQ_LAST    = 5'd19;

   // Size cap and saturation bounds
   localparam int             CAP_INT  = (MAX_DIM < SPAN) ? MAX_DIM : SPAN;
   localparam logic [5:0]     SIZE_CAP = 6'(CAP_INT);
   localparam int             SAT_W    = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam logic signed [SAT_W:0] SAT_HI =
      (SAT_W+1)'((65'sd1 <<< (VALUE_BITS - 1)) - 65'sd1);
   localparam logic signed [SAT_W:0] SAT_LO = -SAT_HI - (SAT_W+1)'(1);

   function automatic size_type eff_size(input size_type s);
      size_type r;
      if (s < 6'd2) begin
         r = 6'd2;
      end else if (s > SIZE_CAP) begin
         r = SIZE_CAP;
      end else begin
         r = s;
      end
      return r;
   endfunction

   // Configuration registers
   size_type size_x_ff, size_y_ff, size_z_ff;
   ufix_type inv_x_ff, inv_y_ff, inv_z_ff;
   logic [2:0] half_mask_ff;

   // Sequencer and datapath registers
   logic                  state_ff, state_in;
   logic [4:0]            step_ff, step_in;
   value_type             pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [65:0]    prod_ff;
   value_type             base_ff, a_ff, rdata_ff;
   value_type             h0_ff, h1_ff, h2_ff;
   index_type             bx_ff, by_ff, bz_ff;
   logic [16:0]           fx_ff, fy_ff, fz_ff;
   logic                  rsp_valid_ff;
   value_type             rsp_value_ff;
   logic                  rsp_sat_ff;

   logic [31:0]           field_mem [0:(1 << ADDR_BITS)-1];
   logic [ADDR_BITS-1:0]  raddr;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= 6'd32;
         size_y_ff    <= 6'd32;
         size_z_ff    <= 6'd32;
         inv_x_ff     <= 32'h0001_0000;
         inv_y_ff     <= 32'h0001_0000;
         inv_z_ff     <= 32'h0001_0000;
         half_mask_ff <= 3'b111;
      end else if (csr_we) begin
         case (csr_index)
            CFG_SIZE_X:    size_x_ff    <= csr_wdata[5:0];
            CFG_SIZE_Y:    size_y_ff    <= csr_wdata[5:0];
            CFG_SIZE_Z:    size_z_ff    <= csr_wdata[5:0];
            CFG_INV_X:     inv_x_ff     <= csr_wdata;
            CFG_INV_Y:     inv_y_ff     <= csr_wdata;
            CFG_INV_Z:     inv_z_ff     <= csr_wdata;
            CFG_HALF_MASK: half_mask_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   logic req_take, wr_take, smp_take, out_free, last_go;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign wr_take   = req_take && (req_kind == KIND_WRITE);
   assign smp_take  = req_take && (req_kind == KIND_SAMPLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_go   = (state_ff == ST_RUN) && (step_ff == SQ_LAST) && out_free;

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (state_ff == ST_IDLE) begin
         if (smp_take) begin
            state_in = ST_RUN;
            step_in  = SQ_MUL_X;
         end
      end else if (step_ff == SQ_LAST) begin
         if (out_free) begin
            state_in = ST_IDLE;
         end
      end else begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= SQ_MUL_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Capture the position of a sample
   always_ff @(posedge clock) begin
      if (smp_take) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
   end

   // Axis conversion of the last product
   size_type          cv_size;
   logic              cv_half;
   logic [4:0]        cv_m1, cv_m2, cv_gi;
   logic [21:0]       cv_g, cv_h, cv_hi, cv_gs;
   logic [20:0]       cv_gc;
   logic              cv_ppos, cv_ovf;
   index_type         cv_base;
   logic [16:0]       cv_frac;

   always_comb begin
      case (step_ff)
         SQ_CONV_X: begin
            cv_size = eff_size(size_x_ff);
            cv_half = half_mask_ff[0];
         end
         SQ_CONV_Y: begin
            cv_size = eff_size(size_y_ff);
            cv_half = half_mask_ff[1];
         end
         default: begin
            cv_size = eff_size(size_z_ff);
            cv_half = half_mask_ff[2];
         end
      endcase
      cv_m1   = 5'(cv_size - 6'd1);
      cv_m2   = 5'(cv_size - 6'd2);
      cv_ppos = !prod_ff[65] && (|prod_ff[64:0]);
      cv_ovf  = |prod_ff[64:38];
      cv_g    = prod_ff[37:16];
      cv_h    = cv_half ? HALF_Q16 : 22'd0;
      cv_hi   = {1'b0, cv_m1, 16'h0000};
      cv_gs   = cv_g - cv_h;
      // clamp to [0, size-1] after the half offset
      if (!cv_ppos || (!cv_ovf && (cv_g < cv_h))) begin
         cv_gc = 21'd0;
      end else if (cv_ovf || (cv_gs > cv_hi)) begin
         cv_gc = cv_hi[20:0];
      end else begin
         cv_gc = cv_gs[20:0];
      end
      cv_gi = cv_gc[20:16];
      // cap the base at size-2; the fraction then reaches 1.0
      if (cv_gi > cv_m2) begin
         cv_base = cv_m2;
         cv_frac = ONE_FRAC;
      end else begin
         cv_base = cv_gi;
         cv_frac = {1'b0, cv_gc[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      case (step_ff)
         SQ_CONV_X: begin
            bx_ff <= cv_base;
            fx_ff <= cv_frac;
         end
         SQ_CONV_Y: begin
            by_ff <= cv_base;
            fy_ff <= cv_frac;
         end
         SQ_CONV_Z: begin
            bz_ff <= cv_base;
            fz_ff <= cv_frac;
         end
         default: ;
      endcase
   end

   // Shared multiplier operand select
   logic signed [32:0] op_a, op_b, diff_rd, diff_h10, diff_h21;
   logic               mul_en, base_from_a, base_from_h0, base_from_h1;

   assign diff_rd  = {rdata_ff[31], rdata_ff} - {a_ff[31], a_ff};
   assign diff_h10 = {h1_ff[31], h1_ff} - {h0_ff[31], h0_ff};
   assign diff_h21 = {h2_ff[31], h2_ff} - {h1_ff[31], h1_ff};

   always_comb begin
      op_a         = diff_rd;
      op_b         = $signed({16'h0000, fx_ff});
      mul_en       = 1'b0;
      base_from_a  = 1'b0;
      base_from_h0 = 1'b0;
      base_from_h1 = 1'b0;
      case (step_ff)
         SQ_MUL_X: begin
            op_a   = {pos_x_ff[31], pos_x_ff};
            op_b   = $signed({1'b0, inv_x_ff});
            mul_en = 1'b1;
         end
         SQ_CONV_X: begin
            op_a   = {pos_y_ff[31], pos_y_ff};
            op_b   = $signed({1'b0, inv_y_ff});
            mul_en = 1'b1;
         end
         SQ_CONV_Y: begin
            op_a   = {pos_z_ff[31], pos_z_ff};
            op_b   = $signed({1'b0, inv_z_ff});
            mul_en = 1'b1;
         end
         SQ_RD_010, SQ_MUL_C01, SQ_RD_011, SQ_MUL_C11: begin
            mul_en      = 1'b1;
            base_from_a = 1'b1;
         end
         SQ_RD_001: begin
            op_a         = diff_h10;
            op_b         = $signed({16'h0000, fy_ff});
            mul_en       = 1'b1;
            base_from_h0 = 1'b1;
         end
         SQ_MUL_D1: begin
            op_a         = diff_h21;
            op_b         = $signed({16'h0000, fy_ff});
            mul_en       = 1'b1;
            base_from_h1 = 1'b1;
         end
         SQ_MUL_R: begin
            op_a         = diff_h10;
            op_b         = $signed({16'h0000, fz_ff});
            mul_en       = 1'b1;
            base_from_h0 = 1'b1;
         end
         default: ;
      endcase
   end

   // Finish a blend: a*65536 + (b-a)*f + half, floored by 16 bits
   logic signed [49:0] fin_sum;
   value_type          blend_res;
   assign fin_sum   = $signed({{2{base_ff[31]}}, base_ff, 16'h0000}) + prod_ff[49:0]
                      + 50'sh8000;
   assign blend_res = fin_sum[47:16];

   // Multiply, hold blend operands and partial results
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (base_from_a) begin
         base_ff <= a_ff;
      end else if (base_from_h0) begin
         base_ff <= h0_ff;
      end else if (base_from_h1) begin
         base_ff <= h1_ff;
      end
      case (step_ff)
         SQ_RD_100, SQ_RD_110, SQ_RD_101, SQ_RD_111: a_ff <= rdata_ff;
         default: ;
      endcase
      case (step_ff)
         SQ_RD_110, SQ_RD_101: h0_ff <= blend_res;
         SQ_FIN_C01, SQ_RD_111, SQ_FIN_D1: h1_ff <= blend_res;
         SQ_FIN_C11: h2_ff <= blend_res;
         default: ;
      endcase
   end

   // Corner address select
   index_type bx1, by1, bz1;
   assign bx1 = bx_ff + 5'd1;
   assign by1 = by_ff + 5'd1;
   assign bz1 = bz_ff + 5'd1;

   always_comb begin
      case (step_ff)
         SQ_RD_000: raddr = {bz_ff, by_ff, bx_ff};
         SQ_RD_100: raddr = {bz_ff, by_ff, bx1};
         SQ_RD_010: raddr = {bz_ff, by1, bx_ff};
         SQ_RD_110: raddr = {bz_ff, by1, bx1};
         SQ_RD_001: raddr = {bz1, by_ff, bx_ff};
         SQ_RD_101: raddr = {bz1, by_ff, bx1};
         SQ_RD_011: raddr = {bz1, by1, bx_ff};
         SQ_RD_111: raddr = {bz1, by1, bx1};
         default:   raddr = {bz_ff, by_ff, bx_ff};
      endcase
   end

   // Field store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_take) begin
         field_mem[{req_entry_z, req_entry_y, req_entry_x}] <= req_entry_value;
      end
      rdata_ff <= field_mem[raddr];
   end

   // Saturate the final blend
   logic signed [SAT_W:0] sat_ext, sat_clip;
   logic                  sat_flag;
   always_comb begin
      sat_ext  = (SAT_W+1)'(blend_res);
      sat_clip = sat_ext;
      sat_flag = 1'b0;
      if (sat_ext > SAT_HI) begin
         sat_clip = SAT_HI;
         sat_flag = 1'b1;
      end else if (sat_ext < SAT_LO) begin
         sat_clip = SAT_LO;
         sat_flag = 1'b1;
      end
   end

   // Output register: load on the last step, drop on transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_go) begin
         rsp_value_ff <= sat_clip[31:0];
         rsp_sat_ff   <= sat_flag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

[src/tgs_checker.sv]
// Port-level assertions for the trilinear grid sampler, and their binding.
module tgs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input tgs_pkg::value_type rsp_sample_value,
   input logic               rsp_saturated
);
   import tgs_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_value)
         && $stable(rsp_saturated))
      else $error("stalled response changed");

   // Drop ready while a sample is at work
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SAMPLE) |=> !req_ready)
      else $error("ready stayed high after a sample transaction");

   // Keep ready after a write
   a_write_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_WRITE) |=> req_ready)
      else $error("write transaction stalled the input");

   // No response right after a sample is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SAMPLE) |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after a sample");

   // Come out of reset idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sample_value (rsp_sample_value),
   .rsp_saturated    (rsp_saturated)
);
